/* rtl/core/ordered_list_table_macros.svh */
// Assertion macros for the ordered list table.
// Depends on clk and arst_n being in scope where a macro is used.
`ifndef ORDERED_LIST_TABLE_MACROS_SVH
`define ORDERED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define OLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/olt_pkg.sv */
// Shared constants and command codes for the ordered list table.
// No dependencies.
package olt_pkg;

	localparam int DEPTH_DEF  = 64;
	localparam int DATA_W_DEF = 32;
	localparam int MODE_W     = 3;
	localparam int POS_W      = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT_AT = 3'd0,
		MODE_SORTED    = 3'd1,
		MODE_ERASE     = 3'd2,
		MODE_REMOVE    = 3'd3,
		MODE_READ      = 3'd4,
		MODE_WRITE     = 3'd5,
		MODE_FIND      = 3'd6
	} mode_t;

endpackage

/* rtl/core/olt_ram.sv */
// Entry store of the ordered list table: one write port, one read port,
// registered read data. Depends on olt_pkg for parameter defaults.
module olt_ram #(
	parameter int DEPTH      = olt_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = olt_pkg::DATA_W_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic signed [DATA_WIDTH-1:0]  wdata,
	input  logic                          re,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic signed [DATA_WIDTH-1:0]  rdata
);

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/ordered_list_table.sv */
// Ordered list table top level: command sequencer around the entry RAM.
// Depends on olt_pkg, olt_ram and ordered_list_table_macros.svh.
//
// A fixed-capacity ordered list of signed words kept in one RAM with a single
// read and a single write port. Commands arrive on the cmd channel and each
// produces exactly one transfer on the rsp channel. Write and commands refused
// at transfer go straight to the result; read first fetches its entry from the
// RAM. Find, remove equal and erase stream the list through the RAM read port,
// one entry per cycle (find stops at the first match). Insert at position p
// moves n - p entries up; sorted insert first scans to its place i and then
// moves n - i entries. A new command is taken while the previous result waits.
`include "ordered_list_table_macros.svh"

module ordered_list_table #(
	parameter int DEPTH      = olt_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = olt_pkg::DATA_W_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [olt_pkg::MODE_W-1:0]          mode,
	input  logic [olt_pkg::POS_W-1:0]           position,
	input  logic signed [DATA_WIDTH-1:0]        data_value,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic                                ok,
	output logic [$clog2(DEPTH)-1:0]            result_index,
	output logic signed [DATA_WIDTH-1:0]        read_value,
	output logic [$clog2(DEPTH+1)-1:0]          removed_count,
	output logic [$clog2(DEPTH+1)-1:0]          item_count,
	output logic                                is_empty
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

	state_t                       state_q;
	olt_pkg::mode_t               mode_q;
	olt_pkg::mode_t               cmd_mode;
	logic signed [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                ptr_q;
	logic [CW-1:0]                end_q;
	logic [CW-1:0]                tgt_q;
	logic [CW-1:0]                wptr_q;
	logic [CW-1:0]                rm_q;
	logic                         res_ok_q;
	logic [IW-1:0]                res_idx_q;
	logic signed [DATA_WIDTH-1:0] res_rd_q;
	logic                         rv_s1;
	logic [IW-1:0]                ra_s1;
	logic                         ok_q;
	logic [IW-1:0]                idx_q;
	logic signed [DATA_WIDTH-1:0] rd_q;
	logic [CW-1:0]                rmo_q;
	logic [CW-1:0]                cnto_q;
	logic                         rsp_valid_q;

	logic                         cmd_fire;
	logic [XW-1:0]                pos_x;
	logic [XW-1:0]                cnt_x;
	logic                         pos_in;
	logic                         pos_le;
	logic signed [DATA_WIDTH-1:0] rdata;
	logic                         eq_s1;
	logic                         lt_s1;
	logic                         hit_s1;
	logic                         shift_end;
	logic                         re;
	logic [IW-1:0]                raddr;
	logic                         we;
	logic [IW-1:0]                waddr;
	logic signed [DATA_WIDTH-1:0] wdata;

	olt_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cmd_ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cmd_mode  = olt_pkg::mode_t'(mode);
	assign pos_x     = XW'(position);
	assign cnt_x     = XW'(cnt_q);
	assign pos_in    = (pos_x < cnt_x);
	assign pos_le    = (pos_x <= cnt_x);

	assign eq_s1 = (rdata == val_q);
	assign lt_s1 = (rdata < val_q);

	always_comb begin
		hit_s1 = 1'b0;
		if (state_q == S_SCAN && rv_s1) begin
			case (mode_q)
				olt_pkg::MODE_SORTED: hit_s1 = !lt_s1;
				olt_pkg::MODE_FIND:   hit_s1 = eq_s1;
				olt_pkg::MODE_READ:   hit_s1 = 1'b1;
				default:              hit_s1 = 1'b0;
			endcase
		end
	end

	assign shift_end = (state_q == S_SHIFT) && !rv_s1 && (ptr_q == tgt_q);

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q[IW-1:0];
		case (state_q)
			S_SCAN: begin
				re = (ptr_q != end_q) && !hit_s1;
			end
			S_SHIFT: begin
				re    = (ptr_q != tgt_q);
				raddr = IW'(ptr_q - CW'(1));
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = ra_s1;
		wdata = rdata;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire && cmd_mode == olt_pkg::MODE_WRITE && pos_in) begin
					we    = 1'b1;
					waddr = IW'(position);
					wdata = data_value;
				end
			end
			S_SCAN: begin
				if (rv_s1 && mode_q == olt_pkg::MODE_ERASE) begin
					we    = 1'b1;
					waddr = IW'(ra_s1 - IW'(1));
				end else if (rv_s1 && mode_q == olt_pkg::MODE_REMOVE && !eq_s1) begin
					we    = 1'b1;
					waddr = wptr_q[IW-1:0];
				end
			end
			S_SHIFT: begin
				if (rv_s1) begin
					we    = 1'b1;
					waddr = IW'(ra_s1 + IW'(1));
				end else if (shift_end) begin
					we    = 1'b1;
					waddr = tgt_q[IW-1:0];
					wdata = val_q;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= olt_pkg::MODE_INSERT_AT;
			val_q       <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			end_q       <= '0;
			tgt_q       <= '0;
			wptr_q      <= '0;
			rm_q        <= '0;
			res_ok_q    <= 1'b0;
			res_idx_q   <= '0;
			res_rd_q    <= '0;
			rv_s1       <= 1'b0;
			ra_s1       <= '0;
			ok_q        <= 1'b0;
			idx_q       <= '0;
			rd_q        <= '0;
			rmo_q       <= '0;
			cnto_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rv_s1 <= re;
			ra_s1 <= raddr;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						mode_q    <= cmd_mode;
						val_q     <= data_value;
						res_ok_q  <= 1'b0;
						res_idx_q <= '0;
						res_rd_q  <= '0;
						rm_q      <= '0;
						wptr_q    <= '0;
						ptr_q     <= '0;
						end_q     <= cnt_q;
						state_q   <= S_DONE;
						case (cmd_mode)
							olt_pkg::MODE_INSERT_AT: begin
								if (cnt_q != FULL && pos_le) begin
									tgt_q   <= CW'(position);
									ptr_q   <= cnt_q;
									state_q <= S_SHIFT;
								end
							end
							olt_pkg::MODE_SORTED: begin
								if (cnt_q != FULL) begin
									state_q <= S_SCAN;
								end
							end
							olt_pkg::MODE_ERASE: begin
								if (pos_in) begin
									ptr_q   <= CW'(position) + CW'(1);
									state_q <= S_SCAN;
								end
							end
							olt_pkg::MODE_REMOVE: begin
								state_q <= S_SCAN;
							end
							olt_pkg::MODE_READ: begin
								if (pos_in) begin
									ptr_q   <= CW'(position);
									end_q   <= CW'(position) + CW'(1);
									state_q <= S_SCAN;
								end
							end
							olt_pkg::MODE_WRITE: begin
								res_ok_q <= pos_in;
							end
							olt_pkg::MODE_FIND: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (rv_s1) begin
						case (mode_q)
							olt_pkg::MODE_SORTED: begin
								if (!lt_s1) begin
									tgt_q   <= CW'(ra_s1);
									ptr_q   <= cnt_q;
									state_q <= S_SHIFT;
								end
							end
							olt_pkg::MODE_REMOVE: begin
								if (eq_s1) begin
									rm_q <= rm_q + CW'(1);
								end else begin
									wptr_q <= wptr_q + CW'(1);
								end
							end
							olt_pkg::MODE_READ: begin
								res_ok_q <= 1'b1;
								res_rd_q <= rdata;
								state_q  <= S_DONE;
							end
							olt_pkg::MODE_FIND: begin
								if (eq_s1) begin
									res_ok_q  <= 1'b1;
									res_idx_q <= ra_s1;
									state_q   <= S_DONE;
								end
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end else if (ptr_q == end_q) begin
						state_q <= S_DONE;
						case (mode_q)
							olt_pkg::MODE_SORTED: begin
								tgt_q   <= cnt_q;
								ptr_q   <= cnt_q;
								state_q <= S_SHIFT;
							end
							olt_pkg::MODE_ERASE: begin
								cnt_q    <= cnt_q - CW'(1);
								res_ok_q <= 1'b1;
							end
							olt_pkg::MODE_REMOVE: begin
								cnt_q    <= wptr_q;
								res_ok_q <= 1'b1;
							end
							default: begin
								res_ok_q <= 1'b0;
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (re) begin
						ptr_q <= ptr_q - CW'(1);
					end
					if (shift_end) begin
						cnt_q     <= cnt_q + CW'(1);
						res_ok_q  <= 1'b1;
						res_idx_q <= tgt_q[IW-1:0];
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						ok_q        <= res_ok_q;
						idx_q       <= res_idx_q;
						rd_q        <= res_rd_q;
						rmo_q       <= rm_q;
						cnto_q      <= cnt_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign ok            = ok_q;
	assign result_index  = idx_q;
	assign read_value    = rd_q;
	assign removed_count = rmo_q;
	assign item_count    = cnto_q;
	assign is_empty      = (cnto_q == '0);

	`OLT_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= FULL, "fill count beyond capacity")
	`OLT_ASSERT_IMPL(a_scan_ptr, state_q == S_SCAN, ptr_q <= end_q, "scan pointer past end")
	`OLT_ASSERT_IMPL(a_shift_room, state_q == S_SHIFT, (ptr_q >= tgt_q) && (cnt_q != FULL), "shift out of range")
	`OLT_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, state_q != S_IDLE, "command transfer left block idle")

endmodule
